/* sv/cfs_pkg.sv */
// shared types and codes for the cholesky factor and solve block
// no dependencies; imported by the controller, datapath and top level
`default_nettype none
package cfs_pkg;

   typedef enum logic [1:0] {
      OP_WR_MATRIX = 2'd0,
      OP_WR_VECTOR = 2'd1,
      OP_FACTOR    = 2'd2,
      OP_SOLVE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      WS_REQ  = 2'd0,
      WS_DIV  = 2'd1,
      WS_SQRT = 2'd2
   } wsel_type;

   localparam int unsigned SIZE_W = 5;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef struct packed {
      logic     m_we;
      logic     v_we;
      wsel_type wsel;
      logic     load_a;
      logic     mul;
      logic     mul_vec;
      logic     acc_init;
      logic     init_vec;
      logic     acc_sub;
      logic     div_start;
      logic     sqrt_start;
      logic     out_load;
      logic     out_status;
      logic     out_fail;
      logic     out_last;
   } ctl_type;

   typedef struct packed {
      logic acc_nonpos;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

/* sv/cfs_if.sv */
// request and response channel interfaces of the cholesky block
// valid/ready handshake with payload; no dependencies
`default_nettype none
interface cfs_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [3:0]         row_index;
   logic [3:0]         col_index;
   logic signed [31:0] value;
   modport source (output valid, operation, row_index, col_index, value, input ready);
   modport sink (input valid, operation, row_index, col_index, value, output ready);
endinterface

interface cfs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [3:0]         result_index;
   logic               status;
   logic               last;
   modport source (output valid, result_value, result_index, status, last, input ready);
   modport sink (input valid, result_value, result_index, status, last, output ready);
endinterface
`default_nettype wire

/* sv/cfs_div.sv */
// iterative signed fixed point divider, one quotient bit per cycle
// saturates to 32 bits; no dependencies
`default_nettype none
module cfs_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    done,
   output logic signed [31:0]      quot
);
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff;
   logic [32:0]      rem_ff;
   logic [31:0]      d_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, fin_ff, done_ff;
   logic             neg_ff, dzero_ff, nneg_ff, nzero_ff;
   logic signed [31:0] quot_ff;

   logic [31:0] num_mag, den_mag;
   logic [32:0] trial;
   logic        qbit;
   logic signed [31:0] sat_q;

   assign num_mag = num[31] ? (~num + 32'd1) : num;
   assign den_mag = den[31] ? (~den + 32'd1) : den;
   assign trial   = {rem_ff[31:0], q_ff[NUM_W-1]};
   assign qbit    = trial >= {1'b0, d_ff};

   always_comb begin
      if (dzero_ff) begin
         if (nzero_ff) sat_q = '0;
         else if (nneg_ff) sat_q = 32'sh8000_0000;
         else sat_q = 32'sh7fff_ffff;
      end else if (neg_ff) begin
         if (q_ff > NUM_W'(64'h8000_0000)) sat_q = 32'sh8000_0000;
         else sat_q = 32'(~q_ff + NUM_W'(1));
      end else begin
         if (q_ff > NUM_W'(64'h7fff_ffff)) sat_q = 32'sh7fff_ffff;
         else sat_q = 32'(q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff     <= {num_mag, FRAC_BITS'(0)};
         rem_ff   <= '0;
         d_ff     <= den_mag;
         neg_ff   <= num[31] ^ den[31];
         dzero_ff <= den == '0;
         nneg_ff  <= num[31];
         nzero_ff <= num == '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? (trial - {1'b0, d_ff}) : trial;
         q_ff   <= {q_ff[NUM_W-2:0], qbit};
      end
      if (fin_ff) quot_ff <= sat_q;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule
`default_nettype wire

/* sv/cfs_sqrt.sv */
// digit recurrence square root of a positive fixed point value
// one root bit per cycle; no dependencies
`default_nettype none
module cfs_sqrt #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] arg,
   output logic                    done,
   output logic signed [31:0]      root
);
   localparam int SQ    = (32 + FRAC_BITS + 1) / 2;
   localparam int RAD_W = 2 * SQ;
   localparam int PAD_W = RAD_W - 32 - FRAC_BITS;
   localparam int CNT_W = $clog2(SQ + 1);

   logic [RAD_W-1:0] rad_ff;
   logic [SQ+1:0]    rem_ff;
   logic [SQ-1:0]    root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;

   logic [SQ+1:0] r2, trial;
   logic          take;

   assign r2    = {rem_ff[SQ-1:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial = {root_ff, 2'b01};
   assign take  = r2 >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(SQ);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= RAD_W'({(PAD_W + 32)'(arg[31:0]), FRAC_BITS'(0)});
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? (r2 - trial) : r2;
         root_ff <= {root_ff[SQ-2:0], take};
      end
   end

   assign done = done_ff;
   assign root = 32'(root_ff);
endmodule
`default_nettype wire

/* sv/cfs_datapath.sv */
// datapath: matrix and vector memories, multiply-accumulate, divider, sqrt
// and the response register; uses cfs_pkg, cfs_div, cfs_sqrt
`default_nettype none
module cfs_datapath #(
   parameter int MAX_N = 16,
   parameter int FRAC_BITS = 16,
   parameter int AW = 8,
   parameter int IDX_W = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfs_pkg::ctl_type   ctl,
   input  wire logic [AW-1:0]      m_addr,
   input  wire logic [IDX_W-1:0]   v_addr,
   input  wire logic [3:0]         out_index,
   input  wire logic signed [31:0] req_value,
   output cfs_pkg::stat_type       stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_value,
   output logic [3:0]              rsp_index,
   output logic                    rsp_status,
   output logic                    rsp_last
);
   import cfs_pkg::*;

   logic signed [31:0] mat_mem_ff [MAX_N*MAX_N];
   logic signed [31:0] vec_mem_ff [MAX_N];
   logic signed [31:0] mrd_ff, vrd_ff, a_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic signed [31:0] acc_sat, mul_b, m_wdata, v_wdata, quot, root, init_src;
   logic               div_done, sqrt_done;
   logic               rsp_valid_ff, rsp_status_ff, rsp_last_ff;
   logic signed [31:0] rsp_value_ff;
   logic [3:0]         rsp_index_ff;

   always_comb begin
      if (acc_ff > 64'sh0000_0000_7fff_ffff) acc_sat = 32'sh7fff_ffff;
      else if (acc_ff < -64'sh0000_0000_8000_0000) acc_sat = 32'sh8000_0000;
      else acc_sat = acc_ff[31:0];
   end

   assign mul_b    = ctl.mul_vec ? vrd_ff : mrd_ff;
   assign init_src = ctl.init_vec ? vrd_ff : mrd_ff;

   always_comb begin
      case (ctl.wsel)
         WS_DIV:  m_wdata = quot;
         WS_SQRT: m_wdata = root;
         default: m_wdata = req_value;
      endcase
      v_wdata = (ctl.wsel == WS_DIV) ? quot : req_value;
   end

   always_ff @(posedge clock) begin
      if (ctl.m_we) mat_mem_ff[m_addr] <= m_wdata;
      mrd_ff <= mat_mem_ff[m_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.v_we) vec_mem_ff[v_addr] <= v_wdata;
      vrd_ff <= vec_mem_ff[v_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) a_ff <= mrd_ff;
      if (ctl.mul) prod_ff <= a_ff * mul_b;
      if (ctl.acc_init) acc_ff <= {{32{init_src[31]}}, init_src};
      else if (ctl.acc_sub) acc_ff <= acc_ff - (prod_ff >>> FRAC_BITS);
   end

   cfs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(ctl.div_start),
      .num(acc_sat), .den(mrd_ff), .done(div_done), .quot(quot)
   );

   cfs_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock(clock), .reset(reset), .start(ctl.sqrt_start),
      .arg(acc_sat), .done(sqrt_done), .root(root)
   );

   // response slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_value_ff  <= ctl.out_status ? 32'sd0 : vrd_ff;
         rsp_index_ff  <= ctl.out_status ? 4'd0 : out_index;
         rsp_status_ff <= ctl.out_fail;
         rsp_last_ff   <= ctl.out_last;
      end
   end

   assign stat.acc_nonpos = acc_ff <= 64'sd0;
   assign stat.div_done   = div_done;
   assign stat.sqrt_done  = sqrt_done;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
endmodule
`default_nettype wire

/* sv/cfs_controller.sv */
// sequencer for element writes, factoring and the two substitution passes
// uses cfs_pkg; drives the datapath by command and status structs
`default_nettype none
module cfs_controller #(
   parameter int MAX_N = 16,
   parameter int AW = 8,
   parameter int IDX_W = 4,
   parameter int CW = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [4:0]       matrix_size,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_op,
   input  wire logic [3:0]       req_row,
   input  wire logic [3:0]       req_col,
   input  wire cfs_pkg::stat_type stat,
   output cfs_pkg::ctl_type      ctl,
   output logic [AW-1:0]         m_addr,
   output logic [IDX_W-1:0]      v_addr,
   output logic [3:0]            out_index
);
   import cfs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_INIT_LD, ST_RD_A, ST_RD_B, ST_MUL, ST_ACC, ST_CHECK,
      ST_DRD, ST_DLD, ST_DIV_WAIT, ST_SQRT_WAIT, ST_STATUS, ST_OUT_RD, ST_OUT_LD
   } state_type;

   typedef enum logic [1:0] {MD_FACTOR, MD_FWD, MD_BACK} mode_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0]    n_ff, n_in, act_n;
   logic             fail_ff, fail_in;
   logic             last_i, inner_empty, inner_last, solving;
   op_type           op;

   function automatic logic [AW-1:0] maddr(input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] c);
      maddr = AW'(int'(r) * MAX_N + int'(c));
   endfunction

   assign op      = op_type'(req_op);
   assign solving = mode_ff != MD_FACTOR;
   assign last_i  = (CW'(i_ff) + CW'(1)) == n_ff;

   always_comb begin
      if (matrix_size == '0) act_n = CW'(1);
      else if (int'(matrix_size) > MAX_N) act_n = CW'(MAX_N);
      else act_n = CW'(matrix_size);
   end

   always_comb begin
      case (mode_ff)
         MD_FACTOR: begin
            inner_empty = j_ff == '0;
            inner_last  = (k_ff + IDX_W'(1)) == j_ff;
         end
         MD_FWD: begin
            inner_empty = i_ff == '0;
            inner_last  = (k_ff + IDX_W'(1)) == i_ff;
         end
         default: begin
            inner_empty = last_i;
            inner_last  = (CW'(k_ff) + CW'(1)) == n_ff;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      fail_in   = fail_ff;
      ctl       = '0;
      m_addr    = '0;
      v_addr    = i_ff;
      out_index = 4'(i_ff);
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            m_addr    = maddr(IDX_W'(req_row), IDX_W'(req_col));
            v_addr    = IDX_W'(req_row);
            ctl.wsel  = WS_REQ;
            if (req_valid) begin
               case (op)
                  OP_WR_MATRIX:
                     ctl.m_we = (int'(req_row) < MAX_N) && (int'(req_col) < MAX_N);
                  OP_WR_VECTOR:
                     ctl.v_we = int'(req_row) < MAX_N;
                  OP_FACTOR: begin
                     mode_in  = MD_FACTOR;
                     i_in     = '0;
                     j_in     = '0;
                     n_in     = act_n;
                     fail_in  = 1'b0;
                     state_in = ST_INIT;
                  end
                  default: begin
                     mode_in  = MD_FWD;
                     i_in     = '0;
                     n_in     = act_n;
                     state_in = ST_INIT;
                  end
               endcase
            end
         end
         ST_INIT: begin
            m_addr   = maddr(i_ff, j_ff);
            state_in = ST_INIT_LD;
         end
         ST_INIT_LD: begin
            m_addr       = maddr(i_ff, j_ff);
            ctl.acc_init = 1'b1;
            ctl.init_vec = solving;
            k_in         = (mode_ff == MD_BACK) ? i_ff + IDX_W'(1) : '0;
            state_in     = inner_empty ? ST_CHECK : ST_RD_A;
         end
         ST_RD_A: begin
            m_addr   = (mode_ff == MD_BACK) ? maddr(k_ff, i_ff) : maddr(i_ff, k_ff);
            v_addr   = k_ff;
            state_in = ST_RD_B;
         end
         ST_RD_B, ST_MUL: begin
            case (mode_ff)
               MD_FACTOR: m_addr = maddr(j_ff, k_ff);
               MD_FWD:    m_addr = maddr(i_ff, k_ff);
               default:   m_addr = maddr(k_ff, i_ff);
            endcase
            v_addr = k_ff;
            if (state_ff == ST_RD_B) begin
               ctl.load_a = 1'b1;
               state_in   = ST_MUL;
            end else begin
               ctl.mul     = 1'b1;
               ctl.mul_vec = solving;
               state_in    = ST_ACC;
            end
         end
         ST_ACC: begin
            ctl.acc_sub = 1'b1;
            k_in        = k_ff + IDX_W'(1);
            state_in    = inner_last ? ST_CHECK : ST_RD_A;
         end
         ST_CHECK: begin
            if (mode_ff == MD_FACTOR && i_ff == j_ff) begin
               if (stat.acc_nonpos) begin
                  fail_in  = 1'b1;
                  state_in = ST_STATUS;
               end else begin
                  ctl.sqrt_start = 1'b1;
                  state_in       = ST_SQRT_WAIT;
               end
            end else begin
               state_in = ST_DRD;
            end
         end
         ST_DRD, ST_DLD: begin
            m_addr = solving ? maddr(i_ff, i_ff) : maddr(j_ff, j_ff);
            if (state_ff == ST_DLD) begin
               ctl.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end else begin
               state_in = ST_DLD;
            end
         end
         ST_DIV_WAIT, ST_SQRT_WAIT: begin
            m_addr   = maddr(i_ff, j_ff);
            ctl.wsel = (state_ff == ST_DIV_WAIT) ? WS_DIV : WS_SQRT;
            if ((state_ff == ST_DIV_WAIT) ? stat.div_done : stat.sqrt_done) begin
               ctl.m_we = !solving;
               ctl.v_we = solving;
               case (mode_ff)
                  MD_FACTOR: begin
                     if (j_ff == i_ff) begin
                        if (last_i) begin
                           state_in = ST_STATUS;
                        end else begin
                           i_in     = i_ff + IDX_W'(1);
                           j_in     = '0;
                           state_in = ST_INIT;
                        end
                     end else begin
                        j_in     = j_ff + IDX_W'(1);
                        state_in = ST_INIT;
                     end
                  end
                  MD_FWD: begin
                     if (last_i) mode_in = MD_BACK;
                     else i_in = i_ff + IDX_W'(1);
                     state_in = ST_INIT;
                  end
                  default: begin
                     if (i_ff == '0) begin
                        state_in = ST_OUT_RD;
                     end else begin
                        i_in     = i_ff - IDX_W'(1);
                        state_in = ST_INIT;
                     end
                  end
               endcase
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               ctl.out_load   = 1'b1;
               ctl.out_status = 1'b1;
               ctl.out_fail   = fail_ff;
               ctl.out_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (stat.out_free) begin
               ctl.out_load = 1'b1;
               ctl.out_last = last_i;
               if (last_i) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MD_FACTOR;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         n_ff     <= CW'(1);
         fail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         fail_ff  <= fail_in;
      end
   end
endmodule
`default_nettype wire

/* sv/cholesky_factor_and_solve.sv */
// cholesky factor and triangular solve, signed fixed point, one shared mac
// element writes go straight to the stores; factor uses the serial divider and
// the square root, solve uses the serial divider; one command in flight at a time
// synchronous active-high reset clears control state; stores stay undefined
`default_nettype none
module cholesky_factor_and_solve #(
   parameter int MAX_N = 16,
   parameter int FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cfs_req_if.sink    req,
   cfs_rsp_if.source  rsp,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data
);
   import cfs_pkg::*;

   // memory address and index widths follow from the matrix order
   localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
   localparam int CW    = $clog2(MAX_N + 1);

   logic [SIZE_W-1:0] matrix_size_ff;
   ctl_type           ctl;
   stat_type          stat;
   logic [AW-1:0]     m_addr;
   logic [IDX_W-1:0]  v_addr;
   logic [3:0]        out_index;

   // matrix size register; the user writes it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_RESET;
      end else if (csr_write_enable) begin
         matrix_size_ff <= csr_write_data;
      end
   end

   // sequencer: accepts a transaction only when idle
   cfs_controller #(.MAX_N(MAX_N), .AW(AW), .IDX_W(IDX_W), .CW(CW)) u_ctrl (
      .clock(clock), .reset(reset), .matrix_size(matrix_size_ff),
      .req_valid(req.valid), .req_ready(req.ready), .req_op(req.operation),
      .req_row(req.row_index), .req_col(req.col_index),
      .stat(stat), .ctl(ctl), .m_addr(m_addr), .v_addr(v_addr),
      .out_index(out_index)
   );

   // stores, arithmetic units and the response register
   cfs_datapath #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS), .AW(AW), .IDX_W(IDX_W)) u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .m_addr(m_addr), .v_addr(v_addr),
      .out_index(out_index), .req_value(req.value), .stat(stat),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_value(rsp.result_value),
      .rsp_index(rsp.result_index), .rsp_status(rsp.status), .rsp_last(rsp.last)
   );
endmodule
`default_nettype wire

/* bench/tb_cholesky_factor_and_solve.sv */
// self-checking testbench for the cholesky factor and solve block
// depends on cfs_pkg, cfs_req_if / cfs_rsp_if and the cholesky_factor_and_solve rtl
`default_nettype none
module tb_cholesky_factor_and_solve;
   import cfs_pkg::*;

   localparam int DIM = 16;
   localparam int FRAC = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               status;
      logic               last;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [4:0] csr_write_data = '0;

   cfs_req_if req_if ();
   cfs_rsp_if rsp_if ();

   cholesky_factor_and_solve dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // mirror of the block state
   logic signed [31:0] shadow_matrix [DIM*DIM];
   logic signed [31:0] shadow_vector [DIM];
   bit                 matrix_written [DIM*DIM];
   bit                 vector_written [DIM];
   logic [4:0]         shadow_size = SIZE_RESET;

   solution_type pending_solutions [$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  no_stall = 0;     // when set neither side idles
   int  random_items = 0;

   // free-running clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // fixed point arithmetic of the block
   // ---------------------------------------------------------------
   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // product of two stored values, floor-shifted back to q16.16
   function automatic longint fx_product(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC;
   endfunction

   function automatic logic signed [31:0] fx_quotient(longint s, logic signed [31:0] d);
      longint num;
      num = s * (64'sd1 <<< FRAC);
      if (d == 0) begin
         // divide by zero saturates with the sign of the numerator
         if (num > 0) return 32'sh7fffffff;
         if (num < 0) return 32'sh80000000;
         return 32'sd0;
      end
      return 32'(clamp32(num / longint'(d)));
   endfunction

   function automatic logic signed [31:0] fx_root(longint s);
      longint unsigned v, root, b;
      v = longint'(s) << FRAC;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return 32'(clamp32(longint'(root)));
   endfunction

   function automatic int order_in_use();
      if (shadow_size == 0) return 1;
      if (shadow_size > DIM) return DIM;
      return shadow_size;
   endfunction

   // in-place factorization of the shadow matrix, returns the status bit
   function automatic logic factorize_shadow();
      int n;
      longint acc;
      n = order_in_use();
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            acc = shadow_matrix[i*DIM+j];
            for (int k = 0; k < j; k++)
               acc -= fx_product(shadow_matrix[i*DIM+k], shadow_matrix[j*DIM+k]);
            acc = clamp32(acc);
            if (i == j) begin
               // not positive definite: stop here, keep what was replaced
               if (acc <= 0) return 1'b1;
               shadow_matrix[i*DIM+i] = fx_root(acc);
            end else begin
               shadow_matrix[i*DIM+j] = fx_quotient(acc, shadow_matrix[j*DIM+j]);
            end
         end
      end
      return 1'b0;
   endfunction

   // forward then back substitution on the shadow vector, queues the solutions
   task automatic solve_shadow();
      int n;
      longint acc;
      solution_type s;
      n = order_in_use();
      for (int i = 0; i < n; i++) begin
         acc = shadow_vector[i];
         for (int j = 0; j < i; j++)
            acc -= fx_product(shadow_matrix[i*DIM+j], shadow_vector[j]);
         shadow_vector[i] = fx_quotient(clamp32(acc), shadow_matrix[i*DIM+i]);
      end
      for (int i = n - 1; i >= 0; i--) begin
         acc = shadow_vector[i];
         for (int j = i + 1; j < n; j++)
            acc -= fx_product(shadow_matrix[j*DIM+i], shadow_vector[j]);
         shadow_vector[i] = fx_quotient(clamp32(acc), shadow_matrix[i*DIM+i]);
      end
      for (int i = 0; i < n; i++) begin
         s.value = shadow_vector[i];
         s.index = 4'(i);
         s.status = 1'b0;
         s.last = (i == n - 1);
         pending_solutions.push_back(s);
      end
   endtask

   // update the mirror for one accepted transaction
   task automatic predict_transaction(op_type op, logic [3:0] r, logic [3:0] c,
                                      logic signed [31:0] v);
      solution_type s;
      case (op)
         OP_WR_MATRIX: begin
            shadow_matrix[r*DIM+c] = v;
            matrix_written[r*DIM+c] = 1;
         end
         OP_WR_VECTOR: begin
            shadow_vector[r] = v;
            vector_written[r] = 1;
         end
         OP_FACTOR: begin
            s.value = '0;
            s.index = '0;
            s.status = factorize_shadow();
            s.last = 1'b1;
            pending_solutions.push_back(s);
         end
         default: solve_shadow();
      endcase
   endtask

   // ---------------------------------------------------------------
   // request driver: drive at falling edge, accept at rising edge
   // ---------------------------------------------------------------
   task automatic send_request(op_type op, int r, int c, logic signed [31:0] v);
      @(negedge clock);
      while (!no_stall && $urandom_range(99) < 34) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.row_index <= 4'(r);
      req_if.col_index <= 4'(c);
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      predict_transaction(op, 4'(r), 4'(c), v);
   endtask

   // drop valid and wait until every solution has come back
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(logic [4:0] sz);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= sz;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      shadow_size = sz;
   endtask

   // never let the block read an entry that was never written
   task automatic fill_unwritten();
      int n;
      n = order_in_use();
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++)
            if (!matrix_written[i*DIM+j])
               send_request(OP_WR_MATRIX, i, j, (i == j) ? 32'sh00010000 : 32'sd0);
         if (!vector_written[i])
            send_request(OP_WR_VECTOR, i, 0, $signed($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // response side: random back-pressure and checking
   // ---------------------------------------------------------------
   always @(negedge clock)
      rsp_if.ready <= no_stall ? 1'b1 : ($urandom_range(99) >= 34);

   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_solutions.size() == 0) begin
            $display("%0t unexpected result: value %h index %0d status %b last %b",
                     $time, rsp_if.result_value, rsp_if.result_index,
                     rsp_if.status, rsp_if.last);
            error_count++;
         end else begin
            want = pending_solutions.pop_front();
            if (rsp_if.result_value !== want.value) begin
               $display("%0t result_value mismatch: expected %h actual %h",
                        $time, want.value, rsp_if.result_value);
               error_count++;
            end
            if (rsp_if.result_index !== want.index) begin
               $display("%0t result_index mismatch: expected %0d actual %0d",
                        $time, want.index, rsp_if.result_index);
               error_count++;
            end
            if (rsp_if.status !== want.status) begin
               $display("%0t status mismatch: expected %b actual %b",
                        $time, want.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t last mismatch: expected %b actual %b",
                        $time, want.last, rsp_if.last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // test tasks
   // ---------------------------------------------------------------

   // size 0 behaves as order 1; one-element factor, solve, failures
   task automatic test_scalar_cases();
      write_size(5'd0);
      send_request(OP_WR_MATRIX, 0, 0, 32'sh00040000);     // 4.0, root is 2.0
      send_request(OP_WR_VECTOR, 0, 0, 32'sh7fffffff);
      send_request(OP_FACTOR, 0, 0, 32'sd0);
      send_request(OP_SOLVE, 0, 0, 32'sd0);
      // stored but outside the area in use
      send_request(OP_WR_MATRIX, 15, 15, 32'sh80000000);
      send_request(OP_WR_VECTOR, 15, 0, 32'sh7fffffff);
      send_request(OP_WR_MATRIX, 15, 0, -32'sd1);
      // negative diagonal is not positive definite
      send_request(OP_WR_MATRIX, 0, 0, 32'sh80000000);
      send_request(OP_FACTOR, 0, 0, 32'sd0);
      // zero diagonal also fails
      send_request(OP_WR_MATRIX, 0, 0, 32'sd0);
      send_request(OP_FACTOR, 0, 0, 32'sd0);
      // divide by zero: positive, negative and zero numerators
      send_request(OP_WR_VECTOR, 0, 0, 32'sd12345);
      send_request(OP_SOLVE, 0, 0, 32'sd0);
      send_request(OP_WR_VECTOR, 0, 0, -32'sd7);
      send_request(OP_SOLVE, 0, 0, 32'sd0);
      send_request(OP_WR_VECTOR, 0, 0, 32'sd0);
      send_request(OP_SOLVE, 0, 0, 32'sd0);
      // solve with an unfactored negative diagonal
      send_request(OP_WR_MATRIX, 0, 0, 32'sh80000000);
      send_request(OP_WR_VECTOR, 0, 0, 32'sh80000000);
      send_request(OP_SOLVE, 0, 0, 32'sd0);
      drain();
   endtask

   // one problem of the order in use: mostly well conditioned, some noise
   task automatic run_problem(bit counted);
      int n;
      bit noisy;
      int items;
      logic signed [31:0] v;
      n = order_in_use();
      noisy = ($urandom_range(99) < 25);
      items = 0;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            if (noisy)
               v = $signed($urandom);
            else if (i == j)
               v = $signed(32'($urandom_range(2*n, 8*n)) << FRAC) | 32'($urandom_range(65535));
            else
               v = $signed(32'($urandom_range(131070)) - 32'sd65535);
            send_request(OP_WR_MATRIX, i, j, v);
            items++;
         end
         v = noisy ? $signed($urandom) : $signed(32'($urandom_range(2097152)) - 32'sd1048576);
         send_request(OP_WR_VECTOR, i, 0, v);
         items++;
      end
      // stray write in the last column; above the diagonal it is never read
      if ($urandom_range(3) == 0) begin
         send_request(OP_WR_MATRIX, $urandom_range(DIM-1), DIM-1, $signed($urandom));
         items++;
      end
      // occasionally solve before factoring
      if ($urandom_range(9) == 0) begin
         send_request(OP_SOLVE, 0, 0, $signed($urandom));
         items++;
      end
      send_request(OP_FACTOR, $urandom_range(15), $urandom_range(15), $signed($urandom));
      send_request(OP_SOLVE, $urandom_range(15), $urandom_range(15), $signed($urandom));
      items += 2;
      // repeated solve on the solved vector
      if ($urandom_range(4) == 0) begin
         send_request(OP_SOLVE, 0, 0, 32'sd0);
         items++;
      end
      if (counted) random_items += items;
   endtask

   // reset default order of 16, full matrix
   task automatic test_full_order();
      run_problem(0);
      drain();
   endtask

   // order sizes above the maximum act as the maximum; reuses stored matrix
   task automatic test_oversize_order();
      write_size(5'd31);
      fill_unwritten();
      send_request(OP_FACTOR, 0, 0, 32'sd0);
      send_request(OP_SOLVE, 0, 0, 32'sd0);
      drain();
   endtask

   // random problems with small orders, with random stalls
   task automatic test_random_problems();
      logic [4:0] sz;
      while (random_items < 20) begin
         case ($urandom_range(9))
            0:       sz = 5'd0;
            1:       sz = 5'd1;
            2, 3, 4: sz = 5'($urandom_range(2, 3));
            default: sz = 5'($urandom_range(4, 6));
         endcase
         write_size(sz);
         fill_unwritten();
         run_problem(1);
      end
      drain();
   endtask

   // a stretch with no idling on either side
   task automatic test_back_to_back();
      no_stall = 1;
      write_size(5'd4);
      run_problem(0);
      drain();
      no_stall = 0;
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      req_if.valid = 1'b0;
      req_if.operation = OP_WR_MATRIX;
      req_if.row_index = '0;
      req_if.col_index = '0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_full_order();
      test_scalar_cases();
      test_back_to_back();
      test_random_problems();
      test_oversize_order();

      drain();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* filelist.f */
sv/cfs_pkg.sv
sv/cfs_if.sv
sv/cfs_div.sv
sv/cfs_sqrt.sv
sv/cfs_datapath.sv
sv/cfs_controller.sv
sv/cholesky_factor_and_solve.sv
bench/tb_cholesky_factor_and_solve.sv
